[rtl/lfo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfo_pkg;

   // sizes of the phase word and of the sine table
   localparam int SINE_TABLE_ADDR_BITS = 10;
   localparam int PHASE_BITS = 16;
   localparam int SINE_QUARTER = 1 << (SINE_TABLE_ADDR_BITS - 2);

   // q28 constants for the elaboration-time table build
   localparam logic [63:0] Q28_ONE_W = 64'd268435456;
   localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
   localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

   // divider unit sizes
   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 37;
   localparam int DIV_QUOT_W = 24;
   localparam int DIV_CNT_W = 5;

   // ceil(2^31 / 15): x / 15 is (x * this) >> 31, exact for x below 2^28
   localparam logic [27:0] RATE_RECIP_15 = 28'h888_8889;

   // configuration register indexes
   localparam logic [2:0] CSR_RATE_HZ = 3'd0;
   localparam logic [2:0] CSR_SYNC_DIVISION = 3'd1;
   localparam logic [2:0] CSR_SHAPE = 3'd2;
   localparam logic [2:0] CSR_DEPTH = 3'd3;
   localparam logic [2:0] CSR_SMOOTH = 3'd4;
   localparam logic [2:0] CSR_SAMPLE_RATE = 3'd5;
   localparam logic [2:0] CSR_MAX_BLOCK_SIZE = 3'd6;

   // shape codes
   localparam logic [1:0] SHAPE_SINE = 2'd0;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
   localparam logic [1:0] SHAPE_SAW = 2'd2;
   localparam logic [1:0] SHAPE_SQUARE = 2'd3;

   localparam logic [3:0] HORNER_TERMS = 4'd11;
   localparam logic [3:0] SQUARINGS = 4'd4;

   // floor((2^32 - 1) / k), entry k; correction step fixes the low bit
   localparam logic [63:0] RECIP_NUM = 64'hFFFF_FFFF;
   typedef logic [15:0][31:0] recip_tab_type;
   localparam recip_tab_type RECIP_TAB = {
      32'd0, 32'd0, 32'd0, 32'd0,
      32'(RECIP_NUM / 11), 32'(RECIP_NUM / 10), 32'(RECIP_NUM / 9),
      32'(RECIP_NUM / 8), 32'(RECIP_NUM / 7), 32'(RECIP_NUM / 6),
      32'(RECIP_NUM / 5), 32'(RECIP_NUM / 4), 32'(RECIP_NUM / 3),
      32'(RECIP_NUM / 2), 32'(RECIP_NUM / 1), 32'd0};

   typedef logic [SINE_QUARTER:0][15:0] sine_tab_type;

   // q28 sine over the first quadrant, fixed taylor series
   function automatic logic [63:0] sin_q28(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 28;
      t = Q28_ONE_W;
      t = Q28_ONE_W - (((x2 * t) >> 28) / 64'd110);
      t = Q28_ONE_W - (((x2 * t) >> 28) / 64'd72);
      t = Q28_ONE_W - (((x2 * t) >> 28) / 64'd42);
      t = Q28_ONE_W - (((x2 * t) >> 28) / 64'd20);
      t = Q28_ONE_W - (((x2 * t) >> 28) / 64'd6);
      t = (x * t) >> 28;
      return (t > Q28_ONE_W) ? Q28_ONE_W : t;
   endfunction

   // q15 sine magnitude for each point of the quarter wave, ends included
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0] x;
      logic [63:0] s;
      for (int m = 0; m <= SINE_QUARTER; m++) begin
         x = (64'(m) * TWO_PI_Q28) >> SINE_TABLE_ADDR_BITS;
         s = sin_q28(x);
         tab[m] = 16'((s + 64'd4096) >> 13);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   typedef enum logic [4:0] {
      ST_IDLE, ST_RATE_START, ST_RATE_WAIT, ST_PHASE, ST_SHAPE, ST_DEPTH,
      ST_TARGET, ST_BYPASS, ST_DEN, ST_Y_START, ST_Y_WAIT, ST_H_MUL,
      ST_H_REC, ST_H_COR, ST_SQ_MUL, ST_SQ_LD, ST_ALPHA, ST_SLEW_MUL,
      ST_SLEW_UPD, ST_OUT
   } lfo_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_MUL_RATE, OP_RATE_LD, OP_MUL_PHASE, OP_SHAPE,
      OP_MUL_DEPTH, OP_TARGET, OP_BYPASS, OP_MUL_DEN, OP_Y_DIV, OP_Y_LD,
      OP_MUL_HF, OP_MUL_HR, OP_H_COR, OP_MUL_SQ, OP_SQ_LD, OP_ALPHA,
      OP_MUL_SLEW, OP_SLEW, OP_OUT
   } lfo_op_type;

   typedef struct packed {
      lfo_op_type op;
      logic [3:0] k;
   } lfo_cmd_type;

   typedef struct packed {
      logic sync_zero;
      logic bypass;
      logic div_done;
      logic slew_full;
   } lfo_status_type;

endpackage

`default_nettype wire

[rtl/lfo_with_tempo_sync_and_slew.sv]
// Tempo-synced lfo with one-pole output slew. Each word on req_ is one audio
// block tick (playhead time in signed q16.16 seconds, tempo in q10.6 bpm,
// block length in samples) and gives exactly one rsp_lfo_value word in q0.16.
// The block works on one tick at a time: req_ready is high only while the
// sequencer is idle, and a finished word waits in the rsp_ output register
// while the next tick can already be taken. Slew is bypassed when smooth
// <= 65; with slew on, the sequencer waits on the 24-step restoring divider
// for the slew exponent and then runs the eleven horner steps of exp() on
// the shared multiplier, skipped when the slew exponent reaches 16 and alpha
// is one. Tempo sync adds the rate multiply in front. A result word not
// taken holds the sequencer in its output state for as long as rsp_ready
// stays low. Configuration is a plain indexed write port; the user must see
// that it is written only while no tick is in flight, as the block itself
// does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module lfo_with_tempo_sync_and_slew (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration writes
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_wdata,
   // tick words in
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_playhead_time,
   input  wire logic [15:0]        req_bpm,
   input  wire logic [12:0]        req_block_samples,
   // lfo words out
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_lfo_value
);

   // sequencer commands and datapath status
   lfo_pkg::lfo_cmd_type    cmd;
   lfo_pkg::lfo_status_type status;

   // state machine: steps the shared multiplier and divider through
   // rate, phase, shape, depth, slew coefficient and level update
   lfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config registers, operand latches, one multiplier, the
   // divider, sine table and the slewed level
   lfo_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_playhead_time (req_playhead_time),
      .req_bpm           (req_bpm),
      .req_block_samples (req_block_samples),
      .rsp_lfo_value     (rsp_lfo_value),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire

[rtl/lfo_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfo_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [lfo_pkg::DIV_NUM_W-1:0]    num,
   input  wire logic [lfo_pkg::DIV_DEN_W-1:0]    den,
   output logic                                  done,
   output logic [lfo_pkg::DIV_QUOT_W-1:0]        quot,
   output logic                                  ovf
);

   localparam int NW = lfo_pkg::DIV_NUM_W;
   localparam int DW = lfo_pkg::DIV_DEN_W;
   localparam int QW = lfo_pkg::DIV_QUOT_W;
   localparam int CW = lfo_pkg::DIV_CNT_W;
   localparam int SW = DW + QW - 1;

   logic [NW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsh_ff, dsh_in;
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          ovf_ff, ovf_in;
   logic [SW-1:0] rem_ext;
   logic [SW-1:0] sub;
   logic          ge;

   always_comb begin
      rem_ext = SW'(rem_ff);
      ge = rem_ext >= dsh_ff;
      sub = rem_ext - dsh_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in = ovf_ff;
      if (start) begin
         rem_in = num;
         dsh_in = {den, {(QW-1){1'b0}}};
         q_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
         // quotient would not fit the unit
         ovf_in = (SW+1)'(num) >= {den, {QW{1'b0}}};
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = sub[NW-1:0];
         end
         q_in = {q_ff[QW-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign ovf = ovf_ff;

endmodule

`default_nettype wire

[rtl/lfo_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfo_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire lfo_pkg::lfo_status_type status,
   output lfo_pkg::lfo_cmd_type        cmd
);

   lfo_pkg::lfo_state_type state_ff, state_in;
   logic [3:0] k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op = lfo_pkg::OP_NONE;
      cmd.k = k_ff;
      req_ready = (state_ff == lfo_pkg::ST_IDLE);
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         lfo_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op = lfo_pkg::OP_LATCH;
               state_in = status.sync_zero ? lfo_pkg::ST_PHASE : lfo_pkg::ST_RATE_START;
            end
         end
         lfo_pkg::ST_RATE_START: begin
            cmd.op = lfo_pkg::OP_MUL_RATE;
            state_in = lfo_pkg::ST_RATE_WAIT;
         end
         lfo_pkg::ST_RATE_WAIT: begin
            cmd.op = lfo_pkg::OP_RATE_LD;
            state_in = lfo_pkg::ST_PHASE;
         end
         lfo_pkg::ST_PHASE: begin
            cmd.op = lfo_pkg::OP_MUL_PHASE;
            state_in = lfo_pkg::ST_SHAPE;
         end
         lfo_pkg::ST_SHAPE: begin
            cmd.op = lfo_pkg::OP_SHAPE;
            state_in = lfo_pkg::ST_DEPTH;
         end
         lfo_pkg::ST_DEPTH: begin
            cmd.op = lfo_pkg::OP_MUL_DEPTH;
            state_in = lfo_pkg::ST_TARGET;
         end
         lfo_pkg::ST_TARGET: begin
            cmd.op = lfo_pkg::OP_TARGET;
            state_in = status.bypass ? lfo_pkg::ST_BYPASS : lfo_pkg::ST_DEN;
         end
         lfo_pkg::ST_BYPASS: begin
            cmd.op = lfo_pkg::OP_BYPASS;
            state_in = lfo_pkg::ST_OUT;
         end
         lfo_pkg::ST_DEN: begin
            cmd.op = lfo_pkg::OP_MUL_DEN;
            state_in = lfo_pkg::ST_Y_START;
         end
         lfo_pkg::ST_Y_START: begin
            cmd.op = lfo_pkg::OP_Y_DIV;
            state_in = lfo_pkg::ST_Y_WAIT;
         end
         lfo_pkg::ST_Y_WAIT: begin
            cmd.op = lfo_pkg::OP_Y_LD;
            if (status.div_done) begin
               if (status.slew_full) begin
                  state_in = lfo_pkg::ST_SLEW_MUL;
               end else begin
                  k_in = lfo_pkg::HORNER_TERMS;
                  state_in = lfo_pkg::ST_H_MUL;
               end
            end
         end
         lfo_pkg::ST_H_MUL: begin
            cmd.op = lfo_pkg::OP_MUL_HF;
            state_in = lfo_pkg::ST_H_REC;
         end
         lfo_pkg::ST_H_REC: begin
            cmd.op = lfo_pkg::OP_MUL_HR;
            state_in = lfo_pkg::ST_H_COR;
         end
         lfo_pkg::ST_H_COR: begin
            cmd.op = lfo_pkg::OP_H_COR;
            if (k_ff == 4'd1) begin
               k_in = lfo_pkg::SQUARINGS;
               state_in = lfo_pkg::ST_SQ_MUL;
            end else begin
               k_in = k_ff - 4'd1;
               state_in = lfo_pkg::ST_H_MUL;
            end
         end
         lfo_pkg::ST_SQ_MUL: begin
            cmd.op = lfo_pkg::OP_MUL_SQ;
            state_in = lfo_pkg::ST_SQ_LD;
         end
         lfo_pkg::ST_SQ_LD: begin
            cmd.op = lfo_pkg::OP_SQ_LD;
            if (k_ff == 4'd1) begin
               state_in = lfo_pkg::ST_ALPHA;
            end else begin
               k_in = k_ff - 4'd1;
               state_in = lfo_pkg::ST_SQ_MUL;
            end
         end
         lfo_pkg::ST_ALPHA: begin
            cmd.op = lfo_pkg::OP_ALPHA;
            state_in = lfo_pkg::ST_SLEW_MUL;
         end
         lfo_pkg::ST_SLEW_MUL: begin
            cmd.op = lfo_pkg::OP_MUL_SLEW;
            state_in = lfo_pkg::ST_SLEW_UPD;
         end
         lfo_pkg::ST_SLEW_UPD: begin
            cmd.op = lfo_pkg::OP_SLEW;
            state_in = lfo_pkg::ST_OUT;
         end
         lfo_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = lfo_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in = lfo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfo_pkg::ST_IDLE;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/lfo_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfo_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [2:0]             csr_index,
   input  wire logic [23:0]            csr_wdata,
   input  wire logic signed [31:0]     req_playhead_time,
   input  wire logic [15:0]            req_bpm,
   input  wire logic [12:0]            req_block_samples,
   output logic [15:0]                 rsp_lfo_value,
   input  wire lfo_pkg::lfo_cmd_type   cmd,
   output lfo_pkg::lfo_status_type     status
);

   localparam int AB = lfo_pkg::SINE_TABLE_ADDR_BITS;
   localparam int PB = lfo_pkg::PHASE_BITS;
   localparam logic [AB-2:0] QUARTER_IDX = (AB-1)'(lfo_pkg::SINE_QUARTER);

   // configuration
   logic [23:0] rate_hz_ff;
   logic [2:0]  sync_ff;
   logic [1:0]  shape_sel_ff;
   logic [16:0] depth_ff;
   logic [16:0] smooth_ff;
   logic [17:0] sample_rate_ff;
   logic [12:0] max_block_ff;

   // working registers
   logic [31:0] t_ff, t_in;
   logic [15:0] bpm_ff, bpm_in;
   logic [12:0] nsamp_ff, nsamp_in;
   logic [23:0] rate_ff, rate_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [16:0] shape_ff, shape_in;
   logic [15:0] target_ff, target_in;
   logic [27:0] f_ff, f_in;
   logic [28:0] e_ff, e_in;
   logic [28:0] v_ff, v_in;
   logic [16:0] alpha_ff, alpha_in;
   logic [23:0] slewed_ff, slewed_in;
   logic [15:0] out_ff, out_in;

   // divider hookup
   logic                              div_start;
   logic [lfo_pkg::DIV_NUM_W-1:0]     div_num;
   logic [lfo_pkg::DIV_DEN_W-1:0]     div_den;
   logic                              div_done;
   logic [lfo_pkg::DIV_QUOT_W-1:0]    div_quot;
   logic                              div_ovf;

   // combinational helpers
   logic [2:0]  sync_eff;
   logic [3:0]  tshift;
   logic [25:0] tnum;
   logic [16:0] n10;
   logic [36:0] yden;
   logic [17:0] sr1;
   logic signed [32:0] mul_a, mul_b;
   logic [PB-1:0] p;
   logic [PB+AB-1:0] sidx_w;
   logic [AB-1:0] sidx;
   logic [1:0]  quad;
   logic [AB-2:0] sm;
   logic [15:0] smag;
   logic [16:0] sine_v;
   logic [PB+1:0] tri_w;
   logic [PB+16:0] tri_s;
   logic [PB+15:0] saw_s;
   logic [16:0] shape_v;
   logic signed [17:0] dval;
   logic signed [35:0] tsum;
   logic signed [20:0] traw;
   logic signed [24:0] diff;
   logic signed [42:0] ssum;
   logic signed [27:0] snew;
   logic [28:0] q0;
   logic [32:0] qk;
   logic [32:0] rrem;
   logic [28:0] qfix;
   logic [29:0] asum;
   logic [24:0] osum;

   always_comb begin
      sync_eff = (sync_ff > 3'd5) ? 3'd5 : sync_ff;
      tshift = {1'b0, sync_eff} + 4'd5;
      tnum = 26'(bpm_ff) << tshift;
      n10 = 17'({nsamp_ff, 3'b000}) + 17'({nsamp_ff, 1'b0});
      yden = {2'b00, prod_ff[34:0]} + {1'b0, prod_ff[34:0], 1'b0};
      sr1 = (sample_rate_ff == 18'd0) ? 18'd1 : sample_rate_ff;

      // divider only serves the slew exponent
      div_start = (cmd.op == lfo_pkg::OP_Y_DIV);
      div_num = {n10, 32'd0};
      div_den = yden;

      // shapes from the phase
      p = prod_ff[31 -: PB];
      sidx_w = {p, {AB{1'b0}}};
      sidx = sidx_w[PB+AB-1:PB];
      quad = sidx[AB-1 -: 2];
      sm = quad[0] ? (QUARTER_IDX - {1'b0, sidx[AB-3:0]}) : {1'b0, sidx[AB-3:0]};
      smag = lfo_pkg::SINE_TAB[sm];
      sine_v = quad[1] ? (17'd32768 - 17'(smag)) : (17'd32768 + 17'(smag));
      tri_w = p[PB-1] ? ((PB+2)'(1) << (PB + 1)) - {1'b0, p, 1'b0}
                      : {1'b0, p, 1'b0};
      tri_s = {tri_w[PB:0], 16'd0} >> PB;
      saw_s = {p, 16'd0} >> PB;
      unique case (shape_sel_ff)
         lfo_pkg::SHAPE_TRIANGLE: shape_v = tri_s[16:0];
         lfo_pkg::SHAPE_SAW:      shape_v = {1'b0, saw_s[15:0]};
         lfo_pkg::SHAPE_SQUARE:   shape_v = p[PB-1] ? 17'd0 : 17'd65536;
         default:                 shape_v = sine_v;
      endcase

      dval = $signed({1'b0, shape_ff}) - 18'sd32768;
      tsum = $signed(prod_ff[35:0]) + 36'sd32768;
      traw = $signed({tsum[35], tsum[35:16]}) + 21'sd32768;

      diff = $signed({1'b0, target_ff, 8'd0}) - $signed({1'b0, slewed_ff});
      ssum = $signed(prod_ff[42:0]) + 43'sd32768;
      snew = $signed({ssum[42], ssum[42:16]}) + $signed({4'd0, slewed_ff});

      // horner divide by k: reciprocal estimate plus one correction
      q0 = prod_ff[60:32];
      qk = 33'(q0) * 33'(cmd.k);
      rrem = 33'(v_ff) - qk;
      qfix = q0 + 29'(rrem >= 33'(cmd.k));
      asum = 30'(lfo_pkg::ONE_Q28 - e_ff) + 30'd2048;
      osum = 25'(slewed_ff) + 25'd128;

      unique case (cmd.op)
         lfo_pkg::OP_MUL_RATE: begin
            // tempo rate over 15 by reciprocal multiplication
            mul_a = $signed(33'(tnum));
            mul_b = $signed(33'(lfo_pkg::RATE_RECIP_15));
         end
         lfo_pkg::OP_MUL_PHASE: begin
            mul_a = $signed({1'b0, t_ff});
            mul_b = $signed(33'(rate_ff));
         end
         lfo_pkg::OP_MUL_DEPTH: begin
            mul_a = 33'(dval);
            mul_b = $signed(33'(depth_ff));
         end
         lfo_pkg::OP_MUL_DEN: begin
            mul_a = $signed(33'(sr1));
            mul_b = $signed(33'(smooth_ff));
         end
         lfo_pkg::OP_MUL_HF: begin
            mul_a = $signed(33'(f_ff));
            mul_b = $signed(33'(e_ff));
         end
         lfo_pkg::OP_MUL_HR: begin
            mul_a = $signed(33'(prod_ff[56:28]));
            mul_b = $signed({1'b0, lfo_pkg::RECIP_TAB[cmd.k]});
         end
         lfo_pkg::OP_MUL_SQ: begin
            mul_a = $signed(33'(e_ff));
            mul_b = $signed(33'(e_ff));
         end
         lfo_pkg::OP_MUL_SLEW: begin
            mul_a = 33'(diff);
            mul_b = $signed(33'(alpha_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      t_in = t_ff;
      bpm_in = bpm_ff;
      nsamp_in = nsamp_ff;
      rate_in = rate_ff;
      prod_in = prod_ff;
      shape_in = shape_ff;
      target_in = target_ff;
      f_in = f_ff;
      e_in = e_ff;
      v_in = v_ff;
      alpha_in = alpha_ff;
      slewed_in = slewed_ff;
      out_in = out_ff;
      unique case (cmd.op)
         lfo_pkg::OP_LATCH: begin
            t_in = req_playhead_time;
            bpm_in = req_bpm;
            nsamp_in = (req_block_samples == 13'd0) ? max_block_ff : req_block_samples;
            rate_in = rate_hz_ff;
         end
         lfo_pkg::OP_RATE_LD: rate_in = prod_ff[54:31];
         lfo_pkg::OP_MUL_RATE, lfo_pkg::OP_MUL_PHASE, lfo_pkg::OP_MUL_DEPTH,
         lfo_pkg::OP_MUL_DEN, lfo_pkg::OP_MUL_HF, lfo_pkg::OP_MUL_SQ,
         lfo_pkg::OP_MUL_SLEW:
            prod_in = mul_a * mul_b;
         lfo_pkg::OP_MUL_HR: begin
            prod_in = mul_a * mul_b;
            v_in = prod_ff[56:28];
         end
         lfo_pkg::OP_SHAPE: shape_in = shape_v;
         lfo_pkg::OP_TARGET: begin
            if (traw < 21'sd0) begin
               target_in = 16'd0;
            end else if (traw > 21'sd65535) begin
               target_in = 16'hFFFF;
            end else begin
               target_in = traw[15:0];
            end
         end
         lfo_pkg::OP_BYPASS: slewed_in = {target_ff, 8'd0};
         lfo_pkg::OP_Y_LD: begin
            f_in = {div_quot[19:0], 8'd0};
            e_in = lfo_pkg::ONE_Q28;
            alpha_in = 17'd65536;
         end
         lfo_pkg::OP_H_COR: e_in = lfo_pkg::ONE_Q28 - qfix;
         lfo_pkg::OP_SQ_LD: e_in = prod_ff[56:28];
         lfo_pkg::OP_ALPHA: alpha_in = asum[28:12];
         lfo_pkg::OP_SLEW: begin
            if (snew < 28'sd0) begin
               slewed_in = 24'd0;
            end else if (snew > 28'sd16777215) begin
               slewed_in = 24'hFFFFFF;
            end else begin
               slewed_in = snew[23:0];
            end
         end
         lfo_pkg::OP_OUT: out_in = osum[24] ? 16'hFFFF : osum[23:8];
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_hz_ff <= 24'd65536;
         sync_ff <= 3'd0;
         shape_sel_ff <= lfo_pkg::SHAPE_SINE;
         depth_ff <= 17'd65536;
         smooth_ff <= 17'd0;
         sample_rate_ff <= 18'd48000;
         max_block_ff <= 13'd512;
         slewed_ff <= 24'd0;
      end else begin
         slewed_ff <= slewed_in;
         if (csr_write_en) begin
            unique case (csr_index)
               lfo_pkg::CSR_RATE_HZ:        rate_hz_ff <= csr_wdata;
               lfo_pkg::CSR_SYNC_DIVISION:  sync_ff <= csr_wdata[2:0];
               lfo_pkg::CSR_SHAPE:          shape_sel_ff <= csr_wdata[1:0];
               lfo_pkg::CSR_DEPTH:          depth_ff <= csr_wdata[16:0];
               lfo_pkg::CSR_SMOOTH:         smooth_ff <= csr_wdata[16:0];
               lfo_pkg::CSR_SAMPLE_RATE:    sample_rate_ff <= csr_wdata[17:0];
               lfo_pkg::CSR_MAX_BLOCK_SIZE: max_block_ff <= csr_wdata[12:0];
               default: begin
               end
            endcase
         end
      end
      t_ff <= t_in;
      bpm_ff <= bpm_in;
      nsamp_ff <= nsamp_in;
      rate_ff <= rate_in;
      prod_ff <= prod_in;
      shape_ff <= shape_in;
      target_ff <= target_in;
      f_ff <= f_in;
      e_ff <= e_in;
      v_ff <= v_in;
      alpha_ff <= alpha_in;
      out_ff <= out_in;
   end

   lfo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .ovf   (div_ovf)
   );

   assign status.sync_zero = (sync_ff == 3'd0);
   assign status.bypass = (smooth_ff <= 17'd65);
   assign status.div_done = div_done;
   assign status.slew_full = div_ovf || (div_quot[23:20] != 4'd0);
   assign rsp_lfo_value = out_ff;

endmodule

`default_nettype wire

[bench/lfo_with_tempo_sync_and_slew_tb.sv]
`timescale 1ns / 1ps

module lfo_with_tempo_sync_and_slew_tb;

   localparam longint Q28 = 64'd268435456;
   localparam longint TWO_PI = 64'd1686629713;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [31:0] playhead_time;
      logic [15:0] bpm;
      logic [12:0] block_samples;
   } tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_playhead_time = '0;
   logic [15:0] req_bpm = '0;
   logic [12:0] req_block_samples = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_lfo_value;

   lfo_with_tempo_sync_and_slew dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model copy of the registers and the slew state
   logic [23:0] m_rate_hz;
   logic [2:0] m_sync;
   logic [1:0] m_shape;
   logic [16:0] m_depth, m_smooth;
   logic [17:0] m_sample_rate;
   logic [12:0] m_max_block;
   logic [23:0] m_level;

   tick_type pending_ticks[$];
   logic [15:0] expected_levels[$];
   int errors = 0;
   int cycles = 0;
   bit hold_req = 1'b0;

   function automatic longint unsigned sine_quarter(longint unsigned x);
      longint unsigned x2, t;
      int dens[5] = '{110, 72, 42, 20, 6};
      x2 = (x * x) >> 28;
      t = Q28;
      for (int i = 0; i < 5; i++) t = Q28 - ((x2 * t) >> 28) / dens[i];
      t = (x * t) >> 28;
      return t > Q28 ? Q28 : t;
   endfunction

   function automatic longint unsigned exp_neg(longint unsigned f);
      longint unsigned t;
      t = Q28;
      for (int k = 11; k >= 1; k--) t = Q28 - ((f * t) >> 28) / k;
      return t;
   endfunction

   function automatic longint wave_level(logic [1:0] sel, longint unsigned p);
      longint unsigned idx, q, r, m, mag, tri_v;
      case (sel)
         lfo_pkg::SHAPE_TRIANGLE: begin
            tri_v = p < 32768 ? 2 * p : 2 * 65536 - 2 * p;
            return (tri_v << 16) >> lfo_pkg::PHASE_BITS;
         end
         lfo_pkg::SHAPE_SAW: return (p << 16) >> lfo_pkg::PHASE_BITS;
         lfo_pkg::SHAPE_SQUARE: return p < 32768 ? 65536 : 0;
         default: begin
            idx = ((p << lfo_pkg::SINE_TABLE_ADDR_BITS) >> lfo_pkg::PHASE_BITS) & 1023;
            q = idx >> (lfo_pkg::SINE_TABLE_ADDR_BITS - 2);
            r = idx & 255;
            m = q[0] ? 256 - r : r;
            mag = (sine_quarter((m * TWO_PI) >> lfo_pkg::SINE_TABLE_ADDR_BITS) + 4096) >> 13;
            return q < 2 ? 32768 + mag : 32768 - mag;
         end
      endcase
   endfunction

   // advances the slew state by one tick, returns the output level
   function automatic logic [15:0] lfo_next(tick_type tk);
      longint unsigned rate, frac, p, n, sr, y, alpha, e;
      longint d, target, diff, s, o;
      int sync;
      sync = m_sync > 5 ? 5 : m_sync;
      if (sync == 0) rate = m_rate_hz;
      else rate = (longint'(tk.bpm) * (64'd1 << (sync - 1)) * 64) / 15;
      frac = (longint'(tk.playhead_time) * rate) & 64'hFFFF_FFFF;
      p = frac >> (32 - lfo_pkg::PHASE_BITS);
      d = wave_level(m_shape, p) - 32768;
      target = 32768 + longint'((d * longint'(m_depth) + (64'sd1 <<< 32) + 32768) >>> 16)
               - 65536;
      if (target < 0) target = 0;
      if (target > 65535) target = 65535;
      if (m_smooth <= 65) begin
         m_level = 24'(target << 8);
      end else begin
         sr = m_sample_rate ? m_sample_rate : 1;
         n = tk.block_samples ? tk.block_samples : m_max_block;
         y = (n * 655360 * 65536) / (3 * sr * longint'(m_smooth));
         if (y >= (64'd16 << 16)) alpha = 65536;
         else begin
            e = exp_neg(y << 8);
            for (int i = 0; i < 4; i++) e = (e * e) >> 28;
            alpha = (Q28 - e + 2048) >> 12;
         end
         diff = (target <<< 8) - longint'(m_level);
         s = longint'(m_level) + ((diff * longint'(alpha) + (64'sd1 <<< 40) + 32768) >>> 16)
             - (64'sd1 <<< 24);
         if (s < 0) s = 0;
         if (s > 24'hFFFFFF) s = 24'hFFFFFF;
         m_level = 24'(s);
      end
      o = (longint'(m_level) + 128) >> 8;
      return o > 65535 ? 16'hFFFF : 16'(o);
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[23:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         lfo_pkg::CSR_RATE_HZ: m_rate_hz = val[23:0];
         lfo_pkg::CSR_SYNC_DIVISION: m_sync = val[2:0];
         lfo_pkg::CSR_SHAPE: m_shape = val[1:0];
         lfo_pkg::CSR_DEPTH: m_depth = val[16:0];
         lfo_pkg::CSR_SMOOTH: m_smooth = val[16:0];
         lfo_pkg::CSR_SAMPLE_RATE: m_sample_rate = val[17:0];
         lfo_pkg::CSR_MAX_BLOCK_SIZE: m_max_block = val[12:0];
         default: ;
      endcase
   endtask

   // queue a tick and its expected level
   task automatic push_tick(logic [31:0] t, logic [15:0] b, logic [12:0] n);
      tick_type tk;
      tk = '{t, b, n};
      pending_ticks.push_back(tk);
      expected_levels.push_back(lfo_next(tk));
   endtask

   task automatic drain;
      while (pending_ticks.size() || expected_levels.size()) @(posedge clock);
      // idle time before the next configuration writes
      repeat (150) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_time();
      case ($urandom_range(3))
         0: return $urandom_range(65535);
         1: return 32'h8000_0000 | $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   // driver: bursts of words with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) void'(pending_ticks.pop_front());
         if (req_valid && !req_ready) begin
            // hold word until taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() > 0) begin
            tick_type nxt;
            nxt = pending_ticks[0];
            req_valid <= 1'b1;
            req_playhead_time <= nxt.playhead_time;
            req_bpm <= nxt.bpm;
            req_block_samples <= nxt.block_samples;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(12, 1);
               gap_left <= $urandom_range(3) == 0 ? 0 : $urandom_range(100);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, plus one long hold-off counted here
   int stall_phase = 0;
   int hold_left = 0;
   bit hold_taken = 1'b0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_phase[11]) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(3) != 0);
   end

   // monitor: compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            $error("lfo_value word with nothing expected: %0d", rsp_lfo_value);
            errors++;
         end else begin
            logic [15:0] exp_v;
            exp_v = expected_levels.pop_front();
            if (rsp_lfo_value !== exp_v) begin
               $error("lfo_value expected %0d actual %0d", exp_v, rsp_lfo_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("lfo_with_tempo_sync_and_slew_tb failed");
         $finish;
      end
   end

   initial begin
      int phase_items;
      m_rate_hz = 65536; m_sync = 0; m_shape = lfo_pkg::SHAPE_SINE; m_depth = 65536;
      m_smooth = 0; m_sample_rate = 48000; m_max_block = 512; m_level = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, then every shape and field extremes
      push_tick(32'h0000_4000, 16'd7680, 13'd0);
      push_tick(32'h7FFF_FFFF, 16'hFFFF, 13'd4096);
      push_tick(32'h8000_0000, 16'd0, 13'd1);
      drain();
      for (int s = 0; s < 4; s++) begin
         csr_write(lfo_pkg::CSR_SHAPE, 32'(s));
         push_tick(32'h0000_2000, 16'd0, 13'd0);
         push_tick(32'hFFFF_C000, 16'd0, 13'd0);
         drain();
      end
      // tempo sync, including out-of-range division
      csr_write(lfo_pkg::CSR_SYNC_DIVISION, 32'd7);
      push_tick(32'h0001_3000, 16'd7680, 13'd128);
      drain();
      csr_write(lfo_pkg::CSR_SYNC_DIVISION, 32'd1);
      push_tick(32'hFFFF_FFFF, 16'hFFFF, 13'd64);
      drain();
      // depth above one, zero depth
      csr_write(lfo_pkg::CSR_SHAPE, 32'(lfo_pkg::SHAPE_SAW));
      csr_write(lfo_pkg::CSR_DEPTH, 32'h1FFFF);
      push_tick(32'h0000_1000, 16'd9000, 13'd64);
      drain();
      csr_write(lfo_pkg::CSR_DEPTH, 32'd0);
      push_tick(32'h0000_1000, 16'd9000, 13'd64);
      drain();
      // slew on with zero sample rate, zero block length, max smooth
      csr_write(lfo_pkg::CSR_DEPTH, 32'd65536);
      csr_write(lfo_pkg::CSR_SMOOTH, 32'd66);
      csr_write(lfo_pkg::CSR_SAMPLE_RATE, 32'd0);
      push_tick(32'h0000_7000, 16'd7000, 13'd0);
      drain();
      csr_write(lfo_pkg::CSR_MAX_BLOCK_SIZE, 32'd0);
      csr_write(lfo_pkg::CSR_SAMPLE_RATE, 32'h3FFFF);
      csr_write(lfo_pkg::CSR_SMOOTH, 32'h1FFFF);
      push_tick(32'h0000_5000, 16'd7000, 13'd0);
      push_tick(32'h0000_5000, 16'd7000, 13'd4096);
      drain();
      csr_write(lfo_pkg::CSR_RATE_HZ, 32'hFFFFFF);
      csr_write(lfo_pkg::CSR_SYNC_DIVISION, 32'd0);
      csr_write(lfo_pkg::CSR_MAX_BLOCK_SIZE, 32'h1FFF);
      push_tick(32'h0000_0001, 16'd0, 13'd0);
      drain();

      // random phases; the first fills the block while the receiver holds off
      for (int ph = 0; ph < 14; ph++) begin
         csr_write(lfo_pkg::CSR_RATE_HZ,
                   $urandom_range(2) == 0 ? $urandom : $urandom_range(1 << 20));
         csr_write(lfo_pkg::CSR_SYNC_DIVISION, $urandom_range(7));
         csr_write(lfo_pkg::CSR_SHAPE, $urandom_range(3));
         csr_write(lfo_pkg::CSR_DEPTH,
                   $urandom_range(3) == 0 ? $urandom : $urandom_range(65536));
         csr_write(lfo_pkg::CSR_SMOOTH, $urandom_range(2) == 0 ? $urandom_range(65)
                                                               : $urandom_range(65536, 66));
         csr_write(lfo_pkg::CSR_SAMPLE_RATE, $urandom_range(4) == 0 ? $urandom
                                                      : $urandom_range(192000, 8000));
         csr_write(lfo_pkg::CSR_MAX_BLOCK_SIZE,
                   $urandom_range(4) == 0 ? $urandom : $urandom_range(4096, 1));
         if (ph == 0) hold_req = 1'b1;
         phase_items = 100;
         for (int i = 0; i < phase_items; i++)
            push_tick(rand_time(), 16'($urandom),
                      13'($urandom_range(4) == 0 ? $urandom : $urandom_range(4096)));
         drain();
      end
      if (errors == 0) $display("lfo_with_tempo_sync_and_slew_tb passed");
      else $display("lfo_with_tempo_sync_and_slew_tb failed");
      $finish;
   end

endmodule

[sim.f]
rtl/lfo_pkg.sv
rtl/lfo_div.sv
rtl/lfo_ctrl.sv
rtl/lfo_dp.sv
rtl/lfo_with_tempo_sync_and_slew.sv
bench/lfo_with_tempo_sync_and_slew_tb.sv
